[src/adcewd_pkg.sv]
// ----------------------------------------------------------------------------
// adcewd_pkg
// Shared types, constants and the chip remap table of the ADC event word
// decoder.
// ----------------------------------------------------------------------------
package adcewd_pkg;

    localparam int APV_CHANNELS = 128;

    localparam int WORD_W   = 32;
    localparam int BYTES_W  = 20;
    localparam int GEO_W    = 27;
    localparam int ICH_W    = 11;
    localparam int ADC_W    = 14;
    localparam int POS_W    = 17;
    localparam int CNT_W    = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [POS_W-1:0]   POS_MAX      = {POS_W{1'b1}};
    localparam logic [POS_W-1:0]   POS_ID       = 17'd2;
    localparam logic [POS_W-1:0]   POS_LENGTH   = 17'd12;
    localparam logic [POS_W-1:0]   POS_PAYLOAD  = 17'd13;
    localparam logic [BYTES_W-1:0] MIN_BYTES    = 20'd64;
    localparam logic [BYTES_W:0]   HEADER_BYTES = 21'd14;

    // Acquisition start and stop ids, compared against the unswapped word
    localparam logic [WORD_W-1:0] ID_START_ACQ = 32'h0001_0002;
    localparam logic [WORD_W-1:0] ID_STOP_ACQ  = 32'h0001_0003;

    // Register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_NUMBERING_MODE = 3'd0;

    typedef enum logic [1:0] {
        MODE_ORIGINAL = 2'd0,
        MODE_SECTOR   = 2'd1,
        MODE_COMPACT  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [GEO_W-1:0] geo_id;
        logic [ICH_W-1:0] channel_index;
        logic [ADC_W-1:0] adc_value;
    } t_hit;

    function automatic logic [3:0] chip_remap(input logic [3:0] chip);
        logic [3:0] m;
        case (chip)
            4'd4:    m = 4'd12;
            4'd5:    m = 4'd13;
            4'd6:    m = 4'd14;
            4'd7:    m = 4'd15;
            4'd12:   m = 4'd4;
            4'd13:   m = 4'd5;
            4'd14:   m = 4'd6;
            4'd15:   m = 4'd7;
            default: m = chip;
        endcase
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

[src/adcewd_cfg.sv]
// ----------------------------------------------------------------------------
// adcewd_cfg
// APB register slave holding the channel numbering mode.
// ----------------------------------------------------------------------------
module adcewd_cfg import adcewd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_mode              o_mode
);

    t_mode r_mode;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_NUMBERING_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ORIGINAL;
        end else if (wr_en) begin
            r_mode <= t_mode'(pwdata[1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_NUMBERING_MODE) begin
            prdata = {{(PDATA_W-2){1'b0}}, r_mode};
        end
    end

    assign o_mode = r_mode;

endmodule

[src/adcewd_core.sv]
// ----------------------------------------------------------------------------
// adcewd_core
// Input word register, event parse state and hit word decode.
// ----------------------------------------------------------------------------
module adcewd_core import adcewd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mode              i_mode,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [WORD_W-1:0]  i_raw_word,
    input  logic               i_first_word,
    input  logic [BYTES_W-1:0] i_event_bytes,
    output logic               o_hit_valid,
    input  logic               i_hit_ready,
    output t_hit               o_hit
);

    logic               r_s1_valid;
    logic [WORD_W-1:0]  r_raw;
    logic               r_first;
    logic [BYTES_W-1:0] r_bytes;

    logic [POS_W-1:0]   r_pos,     n_pos;
    logic [CNT_W-1:0]   r_pw,      n_pw;
    logic [CNT_W-1:0]   r_bc,      n_bc;
    logic [CNT_W-1:0]   r_bi,      n_bi;
    logic               r_dropped, n_dropped;

    logic               fire;
    logic               is_hit;
    logic [WORD_W-1:0]  w;
    logic [POS_W-1:0]   p;
    logic [POS_W-1:0]   rel;
    logic [3:0]         chip;
    logic [3:0]         chip_c;
    logic [3:0]         m;
    logic [2:0]         sec;
    logic [2:0]         modl;
    logic [6:0]         chan;
    logic [CNT_W-1:0]   bi_inc;

    // Stage moves only when the result side can take a word
    assign fire    = r_s1_valid && i_hit_ready;
    assign o_ready = !r_s1_valid || i_hit_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_raw   <= i_raw_word;
            r_first <= i_first_word;
            r_bytes <= i_event_bytes;
        end
    end

    assign w    = swap32(r_raw);
    assign p    = r_first ? '0 : r_pos;
    assign rel  = p - POS_PAYLOAD;
    assign chan = w[20:14];
    assign chip = w[24:21];
    assign modl = w[27:25];
    assign sec  = w[30:28];

    always_comb begin
        n_pos     = (p != POS_MAX) ? p + 1'b1 : p;
        n_pw      = r_pw;
        n_bc      = r_bc;
        n_bi      = r_bi;
        n_dropped = r_dropped;
        is_hit    = 1'b0;
        bi_inc    = r_bi + 1'b1;
        if (p == '0) begin
            n_dropped = r_bytes < MIN_BYTES;
            n_pw      = '0;
            n_bc      = '0;
            n_bi      = '0;
        end else if (p == POS_ID) begin
            if (r_raw == ID_START_ACQ || r_raw == ID_STOP_ACQ) begin
                n_dropped = 1'b1;
            end
        end else if (p == POS_LENGTH) begin
            n_pw = w[31:16];
            // word count against byte count, as the format defines it
            if ((21'(w[31:16]) + HEADER_BYTES) > 21'(r_bytes)) begin
                n_dropped = 1'b1;
            end
        end else if (p >= POS_PAYLOAD && !r_dropped && rel < POS_W'(r_pw)) begin
            if (r_bc == '0) begin
                n_bi = '0;
                n_bc = w[31:16];
            end else begin
                is_hit = !w[31];
                n_bi   = bi_inc;
                if (bi_inc == r_bc) begin
                    n_bc = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_pw      <= '0;
            r_bc      <= '0;
            r_bi      <= '0;
            r_dropped <= 1'b0;
        end else if (fire) begin
            r_pos     <= n_pos;
            r_pw      <= n_pw;
            r_bc      <= n_bc;
            r_bi      <= n_bi;
            r_dropped <= n_dropped;
        end
    end

    // Hit field decode
    assign m      = sec[0] ? chip_remap(chip) + 4'd12 : chip_remap(chip);
    assign chip_c = (sec < 3'd4 && chip > 4'd2) ? chip - 1'b1 : chip;

    always_comb begin
        o_hit.adc_value = w[ADC_W-1:0];
        case (i_mode)
            MODE_ORIGINAL: begin
                o_hit.geo_id        = {sec, 5'd0, modl, 12'd0, chip};
                o_hit.channel_index = ICH_W'(ICH_W'(m) * ICH_W'(APV_CHANNELS))
                                      + ICH_W'(chan);
            end
            MODE_SECTOR: begin
                o_hit.geo_id        = GEO_W'(sec);
                o_hit.channel_index = ICH_W'(ICH_W'(m) * ICH_W'(APV_CHANNELS))
                                      + ICH_W'(chan);
            end
            MODE_COMPACT: begin
                o_hit.geo_id        = GEO_W'(sec);
                o_hit.channel_index = ICH_W'(ICH_W'(chip_c) * ICH_W'(APV_CHANNELS))
                                      + ICH_W'(chan);
            end
            default: begin
                o_hit.geo_id        = '0;
                o_hit.channel_index = '0;
            end
        endcase
    end

    assign o_hit_valid = r_s1_valid && is_hit;

endmodule

[src/adcewd_out.sv]
// ----------------------------------------------------------------------------
// adcewd_out
// Result register holding one decoded hit until the consumer takes it.
// ----------------------------------------------------------------------------
module adcewd_out import adcewd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_hit i_hit,
    output logic o_valid,
    input  logic i_ready,
    output t_hit o_hit
);

    logic r_valid;
    t_hit r_hit;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hit <= i_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

[src/adc_event_word_decoder_unit.sv]
// A hit word is held in the input register, decoded and then held in the result
// register before it shows. Throughput: one word per cycle; the input register
// and the result register each advance whenever the result side is free.
// Reset: synchronous, active low; clears the parse state, both valid flags
// and sets numbering mode to original.
// ----------------------------------------------------------------------------
// adc_event_word_decoder_unit
// Decodes readout event words into ADC hits with geometry and channel ids.
// ----------------------------------------------------------------------------
module adc_event_word_decoder_unit import adcewd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [WORD_W-1:0]  i_raw_word,
    input  logic               i_first_word,
    input  logic [BYTES_W-1:0] i_event_bytes,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [GEO_W-1:0]   o_geo_id,
    output logic [ICH_W-1:0]   o_channel_index,
    output logic [ADC_W-1:0]   o_adc_value
);

    t_mode mode;
    logic  hit_valid;
    logic  hit_ready;
    t_hit  hit;
    t_hit  res;

    adcewd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (mode)
    );

    adcewd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (mode),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_raw_word    (i_raw_word),
        .i_first_word  (i_first_word),
        .i_event_bytes (i_event_bytes),
        .o_hit_valid   (hit_valid),
        .i_hit_ready   (hit_ready),
        .o_hit         (hit)
    );

    adcewd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (hit_valid),
        .o_ready (hit_ready),
        .i_hit   (hit),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hit   (res)
    );

    assign o_geo_id        = res.geo_id;
    assign o_channel_index = res.channel_index;
    assign o_adc_value     = res.adc_value;

endmodule

[src/adcewd_checker.sv]
// ----------------------------------------------------------------------------
// adcewd_port_checks
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module adcewd_port_checks import adcewd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               pready,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [GEO_W-1:0]   o_geo_id,
    input logic [ICH_W-1:0]   o_channel_index,
    input logic [ADC_W-1:0]   o_adc_value
);

    // result side clears out of reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_geo_id)
            && $stable(o_channel_index) && $stable(o_adc_value))
        else $error("stalled result changed");

    // a fresh result needs an earlier accepted word, carried through both registers
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result without accepted word");

    // input stalls only when both stages are full and the consumer stalls
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready && pready)
        else $error("input stalled without output backpressure");

    // geometry id leaves its unused bits clear
    a_geo_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_geo_id[23:19] == 5'd0 && o_geo_id[15:4] == 12'd0)
        else $error("geometry id has stray bits");

endmodule

bind adc_event_word_decoder_unit adcewd_port_checks u_adcewd_port_checks (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .pready          (pready),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_geo_id        (o_geo_id),
    .o_channel_index (o_channel_index),
    .o_adc_value     (o_adc_value)
);

[test/adcewd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcewd_checker
// Watches the word, hit and register channels of the ADC event word decoder.
// Keeps its own copy of the event parse state and numbering mode, predicts
// the hit for every accepted hit word and compares hits in order, field by field.
// ----------------------------------------------------------------------------
module adcewd_checker import adcewd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [WORD_W-1:0]  i_raw_word,
    input  logic               i_first_word,
    input  logic [BYTES_W-1:0] i_event_bytes,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [GEO_W-1:0]   o_geo_id,
    input  logic [ICH_W-1:0]   o_channel_index,
    input  logic [ADC_W-1:0]   o_adc_value,
    output int                 err_count,
    output int                 pending_hits
);

    localparam int ID_WORD         = 2;
    localparam int LEN_WORD        = 12;
    localparam int PAYLOAD_WORD    = 13;
    localparam int MIN_EVENT_BYTES = 64;
    localparam int LEN_SLACK       = 14;
    localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};
    // chip remap, one nibble per chip, chip 0 in the low nibble
    localparam logic [63:0] CHIP_ORDER = 64'h7654_BA98_FEDC_3210;

    logic [POS_W-1:0] word_pos;
    logic [CNT_W-1:0] payload_len;
    logic [CNT_W-1:0] block_len;
    logic [CNT_W-1:0] block_pos;
    logic             drop_event;
    logic [1:0]       mode_q;
    t_hit             hit_q[$];

    task automatic log_mismatch(input string what);
        err_count++;
        if (err_count <= 50) begin
            $display("[%0t] hit check: %s", $time, what);
        end
    endtask

    function automatic t_hit decode_hit(input logic [WORD_W-1:0] w, input logic [1:0] mode);
        t_hit       h;
        logic [2:0] sec;
        logic [2:0] mdl;
        logic [3:0] chip;
        logic [3:0] m;
        logic [6:0] chan;
        int         ich;
        sec  = w[30:28];
        mdl  = w[27:25];
        chip = w[24:21];
        chan = w[20:14];
        h.adc_value     = w[ADC_W-1:0];
        h.geo_id        = '0;
        h.channel_index = '0;
        case (mode)
            MODE_ORIGINAL, MODE_SECTOR: begin
                m = CHIP_ORDER[4*chip +: 4];
                // odd sectors rotate the remapped chip by twelve
                if (sec[0]) begin
                    m = m + 4'd12;
                end
                ich = m * APV_CHANNELS + chan;
                h.channel_index = ich[ICH_W-1:0];
                h.geo_id = (mode == MODE_ORIGINAL) ? {sec, 5'b0, mdl, 12'b0, chip}
                                                   : GEO_W'(sec);
            end
            MODE_COMPACT: begin
                // chips above 2 drop one number in the lower sectors
                if (sec < 3'd4 && chip > 4'd2) begin
                    chip = chip - 4'd1;
                end
                ich = chip * APV_CHANNELS + chan;
                h.channel_index = ich[ICH_W-1:0];
                h.geo_id = GEO_W'(sec);
            end
            default: ;
        endcase
        return h;
    endfunction

    task automatic take_word(input logic [WORD_W-1:0] raw, input logic first,
                             input logic [BYTES_W-1:0] size);
        logic [WORD_W-1:0] w;
        int                p;
        w = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
        if (first) begin
            word_pos = '0;
        end
        p = word_pos;
        if (p == 0) begin
            drop_event  = (size < MIN_EVENT_BYTES);
            payload_len = '0;
            block_len   = '0;
            block_pos   = '0;
        end else if (p == ID_WORD) begin
            if (raw == ID_START_ACQ || raw == ID_STOP_ACQ) begin
                drop_event = 1'b1;
            end
        end else if (p == LEN_WORD) begin
            payload_len = w[31:16];
            // word count against byte count, as the format defines it
            if (int'(payload_len) > int'(size) - LEN_SLACK) begin
                drop_event = 1'b1;
            end
        end else if (p >= PAYLOAD_WORD && !drop_event && p - PAYLOAD_WORD < int'(payload_len)) begin
            if (block_len == '0) begin
                block_pos = '0;
                block_len = w[31:16];
            end else begin
                if (!w[31]) begin
                    hit_q.push_back(decode_hit(w, mode_q));
                end
                block_pos = block_pos + 1'b1;
                if (block_pos == block_len) begin
                    block_len = '0;
                end
            end
        end
        if (word_pos != POS_LIMIT) begin
            word_pos = word_pos + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_hit want;
        if (!i_rst_n) begin
            word_pos    = '0;
            payload_len = '0;
            block_len   = '0;
            block_pos   = '0;
            drop_event  = 1'b0;
            mode_q      = MODE_ORIGINAL;
            hit_q.delete();
        end else begin
            if (psel && penable && pready && paddr == ADDR_NUMBERING_MODE) begin
                if (pwrite) begin
                    mode_q = pwdata[1:0];
                end else if (prdata !== PDATA_W'(mode_q)) begin
                    log_mismatch($sformatf("mode readback %h, want %h", prdata, mode_q));
                end
            end
            if (o_valid && i_ready) begin
                if (hit_q.size() == 0) begin
                    log_mismatch("hit with none expected");
                end else begin
                    want = hit_q.pop_front();
                    if (o_geo_id !== want.geo_id) begin
                        log_mismatch($sformatf("geo_id %h, want %h", o_geo_id, want.geo_id));
                    end
                    if (o_channel_index !== want.channel_index) begin
                        log_mismatch($sformatf("channel_index %h, want %h",
                                               o_channel_index, want.channel_index));
                    end
                    if (o_adc_value !== want.adc_value) begin
                        log_mismatch($sformatf("adc_value %h, want %h",
                                               o_adc_value, want.adc_value));
                    end
                end
            end
            if (i_valid && o_ready) begin
                take_word(i_raw_word, i_first_word, i_event_bytes);
            end
        end
        pending_hits = hit_q.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives event words into the ADC event word decoder: one hand-built event,
// then phases of random events and noise under each numbering mode, with
// random gaps on both channels. The checker predicts and compares the hits.
// ----------------------------------------------------------------------------
module testbench;
    import adcewd_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         PHASES        = 7;
    localparam int         PHASE_WORDS   = 255;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         SETTLE_CYCLES = 4;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [PADDR_W-1:0] paddr          = '0;
    logic [PDATA_W-1:0] pwdata         = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [WORD_W-1:0]  i_raw_word     = '0;
    logic               i_first_word   = 1'b0;
    logic [BYTES_W-1:0] i_event_bytes  = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic [GEO_W-1:0]   o_geo_id;
    logic [ICH_W-1:0]   o_channel_index;
    logic [ADC_W-1:0]   o_adc_value;
    int                 err_count;
    int                 pending_hits;
    bit                 gaps_on        = 1'b0;
    int                 ready_hold     = 0;
    int                 stall_cycles   = 0;
    int                 event_words    = 0;

    always #4 i_clk = ~i_clk;

    adc_event_word_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_raw_word      (i_raw_word),
        .i_first_word    (i_first_word),
        .i_event_bytes   (i_event_bytes),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_geo_id        (o_geo_id),
        .o_channel_index (o_channel_index),
        .o_adc_value     (o_adc_value)
    );

    adcewd_checker hit_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_raw_word      (i_raw_word),
        .i_first_word    (i_first_word),
        .i_event_bytes   (i_event_bytes),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_geo_id        (o_geo_id),
        .o_channel_index (o_channel_index),
        .o_adc_value     (o_adc_value),
        .err_count       (err_count),
        .pending_hits    (pending_hits)
    );

    // hit side: stall in random bursts while gaps are on
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            i_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            ready_hold = $urandom_range(0, 5);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stored words are byte-swapped relative to the decoded view
    function automatic logic [WORD_W-1:0] to_raw(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    task automatic push_word(input logic [WORD_W-1:0] raw, input logic first,
                             input logic [BYTES_W-1:0] size);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_raw_word    <= raw;
        i_first_word  <= first;
        i_event_bytes <= size;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write the mode once the decoder has drained, then read it back
    task automatic set_mode(input logic [1:0] mode);
        while (pending_hits != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NUMBERING_MODE;
        pwdata  <= PDATA_W'(mode);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_event();
        logic [WORD_W-1:0]  words[$];
        logic [WORD_W-1:0]  w;
        logic [BYTES_W-1:0] size;
        int                 pay;
        int                 left;
        int                 hits;
        int                 cut;
        pay = $urandom_range(0, 40);
        for (int k = 0; k < 13; k++) begin
            words.push_back($urandom);
        end
        case ($urandom_range(0, 19))
            0:       words[2] = ID_START_ACQ;
            1:       words[2] = ID_STOP_ACQ;
            default: ;
        endcase
        w = $urandom;
        w[31:16] = pay[15:0];
        words[12] = to_raw(w);
        left = pay;
        while (left > 0) begin
            hits = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
            w = $urandom;
            w[31:16] = hits[15:0];
            words.push_back(to_raw(w));
            left--;
            for (int h = 0; h < hits && left > 0; h++) begin
                w = $urandom;
                w[31] = ($urandom_range(0, 5) == 0);
                words.push_back(to_raw(w));
                left--;
            end
        end
        // trailing words past the payload
        repeat ($urandom_range(0, 3)) words.push_back($urandom);
        case ($urandom_range(0, 9))
            0: size = BYTES_W'($urandom);
            1: size = BYTES_W'($urandom_range(0, 80));
            default: begin
                size = BYTES_W'(4 * words.size() + 4 * $urandom_range(0, 3));
                if (size < 64) begin
                    size = 64;
                end
            end
        endcase
        cut = words.size();
        if ($urandom_range(0, 14) == 0) begin
            cut = $urandom_range(1, words.size());
        end
        for (int k = 0; k < cut; k++) begin
            push_word(words[k], k == 0 && $urandom_range(0, 24) != 0, size);
        end
        event_words += cut;
    endtask

    initial begin
        logic [WORD_W-1:0] opening[$];
        logic [1:0]        phase_modes[PHASES];
        // header with extreme words, an id next to the acquisition ids,
        // seven payload words: empty header, a three-word block with max,
        // zero and debug words, a one-word block, then one word past the end
        opening = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0004, 32'h5A5A_A5A5,
                    32'h0000_0001, 32'h8000_0000, 32'h1234_5678, 32'h9ABC_DEF0,
                    32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_CCCC, 32'hCCCC_3333,
                    to_raw(32'h0007_0000),
                    to_raw(32'h0000_FFFF), to_raw(32'h0003_0000),
                    to_raw(32'h7FFF_FFFF), to_raw(32'h0000_0000),
                    to_raw(32'hFFFF_FFFF), to_raw(32'h0001_1234),
                    to_raw(32'h2CB5_4321), to_raw(32'h1234_5678)};
        phase_modes = '{MODE_SECTOR, MODE_COMPACT, MODE_UNUSED, MODE_ORIGINAL,
                        MODE_COMPACT, MODE_SECTOR, MODE_ORIGINAL};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        gaps_on = 1'b1;
        // no first mark: position zero after reset starts the event
        foreach (opening[k]) begin
            push_word(opening[k], 1'b0, 20'hF_FFFF);
        end
        for (int p = 0; p < PHASES; p++) begin
            i_valid <= 1'b0;
            set_mode(phase_modes[p]);
            event_words = 0;
            while (event_words < PHASE_WORDS) begin
                gaps_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 10)) begin
                        push_word($urandom, 1'($urandom_range(0, 1)), BYTES_W'($urandom));
                    end
                end else begin
                    send_event();
                end
            end
        end
        i_valid <= 1'b0;
        while (pending_hits != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
